// ===== hw/rtl/anisotropic_diffusion_cell_update_assert.svh =====
// Assertion macros for the cell update block; clk and arst_n are taken from the
// module that uses them.
`ifndef ANISOTROPIC_DIFFUSION_CELL_UPDATE_ASSERT_SVH
`define ANISOTROPIC_DIFFUSION_CELL_UPDATE_ASSERT_SVH

// same-cycle implication
`define ADCU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ADCU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/adcu_pkg.sv =====
`default_nettype none

package adcu_pkg;

	localparam int VALUE_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int MAG_W     = VALUE_W + 2;
	localparam int RATIO_W   = 25;
	localparam int SQ_W      = 33;
	localparam int COND_W    = 17;
	localparam int PROD_W    = MAG_W + COND_W;
	localparam int EXP_BITS  = 21;

	localparam logic [30:0]        SQRT2_Q30 = 31'd1518500250;
	localparam logic [RATIO_W-1:0] RATIO_CAP = 25'd16777216;
	localparam logic [COND_W-1:0]  COND_ONE  = 17'd65536;

	localparam logic [1:0] MODE_EXP   = 2'd0;
	localparam logic [1:0] MODE_QUAD  = 2'd1;
	localparam logic [1:0] MODE_TUKEY = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	localparam int LANE_LAT  = 53;
	localparam int MERGE_LAT = 8;
	localparam int LANES     = 8;

	// exp(-2^k) in Q0.32, k = -16 .. 4
	localparam logic [31:0] EXP_NEG_POW2 [EXP_BITS] = '{
		32'd4294901761, 32'd4294836226, 32'd4294705160, 32'd4294443040, 32'd4293918848,
		32'd4292870656, 32'd4290775039, 32'd4286586875, 32'd4278222805, 32'd4261543595,
		32'd4228380000, 32'd4162825044, 32'd4034748382, 32'd3790295335, 32'd3344923893,
		32'd2605029347, 32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801,
		32'd483
	};

	typedef struct packed {
		logic signed [VALUE_W-1:0] centre_value;
		logic signed [VALUE_W-1:0] north_value;
		logic signed [VALUE_W-1:0] east_value;
		logic signed [VALUE_W-1:0] south_value;
		logic signed [VALUE_W-1:0] west_value;
		logic signed [VALUE_W-1:0] northwest_value;
		logic signed [VALUE_W-1:0] northeast_value;
		logic signed [VALUE_W-1:0] southeast_value;
		logic signed [VALUE_W-1:0] southwest_value;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] smoothed_value;
		logic                      saturated_flag;
	} out_item_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [31:0]      k;
		logic [MAG_W-1:0] s_thresh;
	} lane_cfg_t;

	typedef struct packed {
		logic [PROD_W-1:0] prod;
		logic              neg;
		logic              over;
	} lane_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/anisotropic_diffusion_cell_update.sv =====
// Anisotropic diffusion update of one raster cell, eight neighbours.
// Input channel (in_valid / in_ready / in_data): one transaction carries the centre
// cell and its eight neighbours, signed Q16.16. Output channel (out_valid /
// out_ready / out_data): one transaction per input, the smoothed centre and a
// flag that marks a clipped result.
// Eight lanes, one per direction, each run a fully pipelined path: gradient,
// ratio to K through a 25-stage restoring divider, square, then the conductance
// (a 21-stage exponential product chain, a 17-stage divider for the quadratic
// form, one multiply for Tukey). A merging pipeline sums the lanes, applies the
// rate and saturates. One transaction is taken every cycle while the output
// does not stall, set by the one-stage-per-step lanes.
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops; it resumes as the waiting result is taken.
// Reset clears the pipeline valid bits and loads the registers with mode
// exponential, K = 1.0 and rate 0.25. Registers sit on an APB port at 0x0,
// 0x4 and 0x8; write them only while the block is empty.
`default_nettype none

`include "anisotropic_diffusion_cell_update_assert.svh"

module anisotropic_diffusion_cell_update (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire adcu_pkg::in_item_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output adcu_pkg::out_item_t       out_data,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [3:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic      [31:0]          prdata,
	output logic                      pready
);

	localparam int VW    = adcu_pkg::VALUE_W;
	localparam int MW    = adcu_pkg::MAG_W;
	localparam int TOTAL = adcu_pkg::LANE_LAT + adcu_pkg::MERGE_LAT;
	localparam int SP_W  = 32 + 31;

	localparam logic [1:0] REG_MODE      = 2'd0;
	localparam logic [1:0] REG_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_RATE      = 2'd2;

	localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

	logic [1:0]           mode_q;
	logic [31:0]          thresh_q;
	logic [15:0]          rate_q;
	logic [31:0]          k_eff;
	logic [SP_W-1:0]      sprod_q;
	logic [MW-1:0]        s_thresh_q;
	logic                 wr;
	logic                 en;
	logic [TOTAL-1:0]     vld_s;
	logic signed [VW-1:0] centre_s [adcu_pkg::LANE_LAT];
	logic signed [VW-1:0] nb [adcu_pkg::LANES];
	adcu_pkg::lane_cfg_t  lane_cfg;
	adcu_pkg::lane_out_t  lane_res [adcu_pkg::LANES];

	// register port: writes complete in the access phase, never wait
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= adcu_pkg::MODE_EXP;
			thresh_q <= 32'd65536;
			rate_q   <= 16'd16384;
		end else if (wr) begin
			case (paddr[3:2])
				REG_MODE:      mode_q   <= pwdata[1:0];
				REG_THRESHOLD: thresh_q <= pwdata;
				REG_RATE:      rate_q   <= pwdata[15:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MODE:      prdata = {30'd0, mode_q};
			REG_THRESHOLD: prdata = thresh_q;
			REG_RATE:      prdata = {16'd0, rate_q};
			default:       prdata = '0;
		endcase
	end

	// a zero threshold behaves as the smallest legal one
	assign k_eff = (thresh_q == '0) ? 32'd1 : thresh_q;

	// Tukey limit K * sqrt 2, refreshed continuously from the threshold register
	always_ff @(posedge clk) begin
		sprod_q    <= SP_W'(k_eff) * SP_W'(adcu_pkg::SQRT2_Q30);
		s_thresh_q <= MW'((sprod_q + (SP_W'(1) << 29)) >> 30);
	end

	assign lane_cfg = '{mode: mode_q, k: k_eff, s_thresh: s_thresh_q};

	// advance the whole pipeline unless a finished result is held up
	assign en        = !vld_s[TOTAL-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_s[TOTAL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[TOTAL-2:0], in_valid};
		end
	end

	// hold the centre alongside the lanes until the merge needs it
	always_ff @(posedge clk) begin
		if (en) begin
			centre_s[0] <= in_data.centre_value;
			for (int i = 1; i < adcu_pkg::LANE_LAT; i++) centre_s[i] <= centre_s[i-1];
		end
	end

	assign nb[0] = in_data.north_value;
	assign nb[1] = in_data.east_value;
	assign nb[2] = in_data.south_value;
	assign nb[3] = in_data.west_value;
	assign nb[4] = in_data.northwest_value;
	assign nb[5] = in_data.northeast_value;
	assign nb[6] = in_data.southeast_value;
	assign nb[7] = in_data.southwest_value;

	// axis lanes first, then the four diagonals
	for (genvar i = 0; i < adcu_pkg::LANES; i++) begin : g_lane
		adcu_lane #(.DIAG(i >= 4)) u_lane (
			.clk       (clk),
			.en        (en),
			.cfg       (lane_cfg),
			.centre    (in_data.centre_value),
			.neighbour (nb[i]),
			.result    (lane_res[i])
		);
	end

	adcu_merge u_merge (
		.clk    (clk),
		.en     (en),
		.mode   (mode_q),
		.rate   (rate_q),
		.lanes  (lane_res),
		.centre (centre_s[adcu_pkg::LANE_LAT-1]),
		.result (out_data)
	);

	`ADCU_ASSERT_IMP(a_sat_at_limit, out_valid && out_data.saturated_flag, out_data.smoothed_value == VAL_MAX || out_data.smoothed_value == VAL_MIN, "clipped result not at a range limit")
	`ADCU_ASSERT_NXT(a_stall_freezes, !en, $stable(vld_s) && $stable(out_data), "pipeline moved during a stall")

endmodule

`default_nettype wire

// ===== hw/rtl/adcu_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per stage. rem0 must be below den.
module adcu_div #(
	parameter int DEN_W = 32,
	parameter int STEPS = 25
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [DEN_W-1:0] rem0,
	input  wire logic [STEPS-1:0] bits,
	input  wire logic [DEN_W-1:0] den,
	output logic      [STEPS-1:0] quo
);

	logic [DEN_W-1:0] rem_s  [STEPS];
	logic [STEPS-1:0] quo_s  [STEPS];
	logic [STEPS-1:0] bits_s [STEPS];
	logic [DEN_W-1:0] den_s  [STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic [DEN_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [STEPS-1:0] bits_in;
		logic [STEPS-1:0] quo_in;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;

		if (i == 0) begin : g_first
			assign rem_in  = rem0;
			assign den_in  = den;
			assign bits_in = bits;
			assign quo_in  = '0;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign den_in  = den_s[i-1];
			assign bits_in = bits_s[i-1];
			assign quo_in  = quo_s[i-1];
		end

		assign trial = {rem_in, bits_in[STEPS-1]};
		assign diff  = trial - {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
				quo_s[i]  <= {quo_in[STEPS-2:0], ~diff[DEN_W]};
				bits_s[i] <= {bits_in[STEPS-2:0], 1'b0};
				den_s[i]  <= den_in;
			end
		end
	end

	assign quo = quo_s[STEPS-1];

endmodule

`default_nettype wire

// ===== hw/rtl/adcu_lane.sv =====
`default_nettype none

// One gradient direction: magnitude, ratio to K, conductance, weighted gradient.
module adcu_lane #(
	parameter bit DIAG = 1'b0
) (
	input  wire logic                                 clk,
	input  wire logic                                 en,
	input  wire adcu_pkg::lane_cfg_t                  cfg,
	input  wire logic signed [adcu_pkg::VALUE_W-1:0]  centre,
	input  wire logic signed [adcu_pkg::VALUE_W-1:0]  neighbour,
	output adcu_pkg::lane_out_t                       result
);

	localparam int VW       = adcu_pkg::VALUE_W;
	localparam int MW       = adcu_pkg::MAG_W;
	localparam int DPROD_W  = VW + 1 + 31;
	localparam int RW       = adcu_pkg::RATIO_W;
	localparam int FB       = adcu_pkg::FRAC_BITS;
	localparam int RSH      = RW - FB;
	localparam int SQW      = adcu_pkg::SQ_W;
	localparam int CW       = adcu_pkg::COND_W;
	localparam int EB       = adcu_pkg::EXP_BITS;
	localparam int ACC_W    = 33;
	localparam int EPROD_W  = ACC_W + 32;
	localparam int QSTEPS   = CW;
	localparam int QPAD     = EB - QSTEPS;
	localparam int TPAD     = EB - 1;
	localparam int SIDE_LEN = RW + 1 + EB + 1;
	localparam int SIDE_W   = MW + 2;

	logic signed [VW:0]       diff;
	logic [VW:0]              mag_s1;
	logic                     neg_s1, neg_s2, neg_s3, neg_s4;
	logic [DPROD_W-1:0]       dprod_s2;
	logic [MW-1:0]            m_s3, m_s4;
	logic                     capped_s4, over_s4;
	logic [31:0]              rrem0;
	logic [RW-1:0]            rbits;
	logic [RW-1:0]            rquo;
	logic [SIDE_W-1:0]        side_s [SIDE_LEN];
	logic                     cap_s  [RW];
	logic [RW-1:0]            t;
	logic [2*RW-1:0]          sq_s30;
	logic [SQW-1:0]           r;
	logic [ACC_W-1:0]         acc_s   [EB];
	logic [EB-1:0]            rbits_s [EB];
	logic                     ezero_s [EB];
	logic [SQW-1:0]           qden, qnum;
	logic [CW-1:0]            qquo;
	logic [CW-1:0]            qpad_s [QPAD];
	logic [31:0]              half;
	logic [CW-1:0]            h;
	logic [2*CW-1:0]          tsq;
	logic [CW-1:0]            tk_s31;
	logic [CW-1:0]            tkd_s [TPAD];
	logic [CW-1:0]            c_s52;
	logic [MW-1:0]            m_s52;
	logic [adcu_pkg::PROD_W-1:0] prod_s53;
	logic                     neg_s53, over_s53;

	assign diff = {neighbour[VW-1], neighbour} - {centre[VW-1], centre};

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= diff[VW];
			mag_s1 <= diff[VW] ? $unsigned(-diff) : $unsigned(diff);
			neg_s2 <= neg_s1;
			neg_s3 <= neg_s2;
			neg_s4 <= neg_s3;
		end
	end

	// diagonals scaled by sqrt 2, rounded half up
	if (DIAG) begin : g_diag
		always_ff @(posedge clk) begin
			if (en) begin
				dprod_s2 <= DPROD_W'(mag_s1) * DPROD_W'(adcu_pkg::SQRT2_Q30);
				m_s3     <= MW'((dprod_s2 + (DPROD_W'(1) << 29)) >> 30);
			end
		end
	end else begin : g_axis
		always_ff @(posedge clk) begin
			if (en) begin
				dprod_s2 <= DPROD_W'(mag_s1);
				m_s3     <= MW'(dprod_s2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s4      <= m_s3;
			capped_s4 <= MW'(m_s3 >> RSH) >= MW'(cfg.k);
			over_s4   <= m_s3 > cfg.s_thresh;
		end
	end

	// ratio m * 2^16 / K; the high part is already known to be below K unless capped
	assign rrem0 = capped_s4 ? '0 : 32'(m_s4 >> RSH);
	assign rbits = {m_s4[RSH-1:0], {FB{1'b0}}};

	adcu_div #(.DEN_W(32), .STEPS(RW)) u_ratio_div (
		.clk  (clk),
		.en   (en),
		.rem0 (rrem0),
		.bits (rbits),
		.den  (cfg.k),
		.quo  (rquo)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= {m_s4, neg_s4, over_s4};
			cap_s[0]  <= capped_s4;
			for (int i = 1; i < SIDE_LEN; i++) side_s[i] <= side_s[i-1];
			for (int i = 1; i < RW; i++) cap_s[i] <= cap_s[i-1];
		end
	end

	assign t = (cap_s[RW-1] || (rquo > adcu_pkg::RATIO_CAP)) ? adcu_pkg::RATIO_CAP : rquo;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s30 <= (2*RW)'(t) * (2*RW)'(t);
		end
	end

	assign r = sq_s30[FB+SQW-1:FB];

	// exponential: one table factor per set bit of r
	for (genvar e = 0; e < EB; e++) begin : g_exp
		logic [ACC_W-1:0]   acc_in;
		logic [EB-1:0]      rb_in;
		logic               z_in;
		logic [EPROD_W-1:0] eprod;

		if (e == 0) begin : g_first
			assign acc_in = ACC_W'(1) << 32;
			assign rb_in  = r[EB-1:0];
			assign z_in   = |r[SQW-1:EB];
		end else begin : g_next
			assign acc_in = acc_s[e-1];
			assign rb_in  = rbits_s[e-1];
			assign z_in   = ezero_s[e-1];
		end

		assign eprod = EPROD_W'(acc_in) * EPROD_W'(adcu_pkg::EXP_NEG_POW2[e]);

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[e]   <= rb_in[e] ? ACC_W'((eprod + (EPROD_W'(1) << 31)) >> 32) : acc_in;
				rbits_s[e] <= rb_in;
				ezero_s[e] <= z_in;
			end
		end
	end

	// quadratic: 2^32 / (1 + r), rounded half up
	assign qden = SQW'(adcu_pkg::COND_ONE) + r;
	assign qnum = (SQW'(1) << 32) + (qden >> 1);

	adcu_div #(.DEN_W(SQW), .STEPS(QSTEPS)) u_quad_div (
		.clk  (clk),
		.en   (en),
		.rem0 (SQW'(qnum[SQW-1:QSTEPS])),
		.bits (qnum[QSTEPS-1:0]),
		.den  (qden),
		.quo  (qquo)
	);

	// Tukey: half of (1 - r/2)^2
	assign half = r[SQW-1:1];
	assign h    = (half >= 32'(adcu_pkg::COND_ONE)) ? '0
		: CW'(32'(adcu_pkg::COND_ONE) - half);
	assign tsq  = (2*CW)'(h) * (2*CW)'(h);

	always_ff @(posedge clk) begin
		if (en) begin
			tk_s31    <= CW'((tsq + (2*CW)'(adcu_pkg::COND_ONE)) >> 17);
			tkd_s[0]  <= tk_s31;
			qpad_s[0] <= qquo;
			for (int i = 1; i < TPAD; i++) tkd_s[i] <= tkd_s[i-1];
			for (int i = 1; i < QPAD; i++) qpad_s[i] <= qpad_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (cfg.mode)
				adcu_pkg::MODE_EXP:   c_s52 <= ezero_s[EB-1] ? '0
					: CW'((acc_s[EB-1] + ACC_W'(32768)) >> 16);
				adcu_pkg::MODE_QUAD:  c_s52 <= qpad_s[QPAD-1];
				adcu_pkg::MODE_TUKEY: c_s52 <= tkd_s[TPAD-1];
				default:              c_s52 <= '0;
			endcase
			prod_s53 <= adcu_pkg::PROD_W'(m_s52) * adcu_pkg::PROD_W'(c_s52);
			neg_s53  <= side_s[SIDE_LEN-1][1];
			over_s53 <= side_s[SIDE_LEN-1][0];
		end
	end

	assign m_s52 = side_s[SIDE_LEN-1][SIDE_W-1:2];

	assign result = '{prod: prod_s53, neg: neg_s53, over: over_s53};

endmodule

`default_nettype wire

// ===== hw/rtl/adcu_merge.sv =====
`default_nettype none

// Sum the lanes, scale by the rate, add to the centre and saturate.
module adcu_merge (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic [1:0]                          mode,
	input  wire logic [15:0]                         rate,
	input  wire adcu_pkg::lane_out_t                 lanes [adcu_pkg::LANES],
	input  wire logic signed [adcu_pkg::VALUE_W-1:0] centre,
	output adcu_pkg::out_item_t                      result
);

	localparam int VW   = adcu_pkg::VALUE_W;
	localparam int T_W  = adcu_pkg::PROD_W + 1;
	localparam int S1_W = T_W + 1;
	localparam int S2_W = T_W + 2;
	localparam int S3_W = T_W + 3;
	localparam int M1_W = S3_W - 16;
	localparam int P_W  = M1_W + 16;
	localparam int D_W  = M1_W + 1;
	localparam int R_W  = D_W + 1;
	localparam logic signed [R_W-1:0] VMAX = R_W'({1'b0, {(VW-1){1'b1}}});
	localparam logic signed [R_W-1:0] VMIN = -VMAX - R_W'(1);

	logic                   any_over;
	logic                   kill;
	logic signed [T_W-1:0]  term   [adcu_pkg::LANES];
	logic signed [S1_W-1:0] sum_s1 [4];
	logic signed [S2_W-1:0] sum_s2 [2];
	logic signed [S3_W-1:0] sum_s3;
	logic [S3_W-1:0]        abs_s4;
	logic [M1_W-1:0]        mag_s5;
	logic [P_W-1:0]         p_s6;
	logic [M1_W-1:0]        mag2;
	logic signed [D_W-1:0]  delta_s7;
	logic                   sign_s4, sign_s5, sign_s6;
	logic signed [VW-1:0]   centre_s [7];
	logic signed [R_W-1:0]  res;
	adcu_pkg::out_item_t    res_s8;

	always_comb begin
		any_over = 1'b0;
		for (int i = 0; i < adcu_pkg::LANES; i++) any_over = any_over | lanes[i].over;
	end

	// Tukey drops every conductance once any gradient is past the limit; mode none drops them always
	assign kill = (mode == adcu_pkg::MODE_NONE) || ((mode == adcu_pkg::MODE_TUKEY) && any_over);

	always_comb begin
		for (int i = 0; i < adcu_pkg::LANES; i++) begin
			if (kill) begin
				term[i] = '0;
			end else if (lanes[i].neg) begin
				term[i] = -$signed(T_W'(lanes[i].prod));
			end else begin
				term[i] = $signed(T_W'(lanes[i].prod));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) sum_s1[j] <= S1_W'(term[2*j]) + S1_W'(term[2*j+1]);
			for (int j = 0; j < 2; j++) sum_s2[j] <= S2_W'(sum_s1[2*j]) + S2_W'(sum_s1[2*j+1]);
			sum_s3   <= S3_W'(sum_s2[0]) + S3_W'(sum_s2[1]);
			sign_s4  <= sum_s3[S3_W-1];
			abs_s4   <= sum_s3[S3_W-1] ? $unsigned(-sum_s3) : $unsigned(sum_s3);
			sign_s5  <= sign_s4;
			mag_s5   <= M1_W'((abs_s4 + S3_W'(32768)) >> 16);
			sign_s6  <= sign_s5;
			p_s6     <= P_W'(mag_s5) * P_W'(rate);
			delta_s7 <= sign_s6 ? -$signed({1'b0, mag2}) : $signed({1'b0, mag2});
			centre_s[0] <= centre;
			for (int i = 1; i < 7; i++) centre_s[i] <= centre_s[i-1];
		end
	end

	assign mag2 = M1_W'((p_s6 + P_W'(32768)) >> 16);
	assign res  = R_W'(centre_s[6]) + R_W'(delta_s7);

	always_ff @(posedge clk) begin
		if (en) begin
			if (res > VMAX) begin
				res_s8.smoothed_value <= VW'(VMAX);
				res_s8.saturated_flag <= 1'b1;
			end else if (res < VMIN) begin
				res_s8.smoothed_value <= VW'(VMIN);
				res_s8.saturated_flag <= 1'b1;
			end else begin
				res_s8.smoothed_value <= VW'(res);
				res_s8.saturated_flag <= 1'b0;
			end
		end
	end

	assign result = res_s8;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// register map: one word per register
	localparam logic [3:0] REG_MODE = 4'h0;
	localparam logic [3:0] REG_K    = 4'h4;
	localparam logic [3:0] REG_RATE = 4'h8;
	// cycles to let pass once the last result is out, covers the pipe
	localparam int DRAIN_CYCLES = 80;
	localparam int HOLD_CYCLES  = 200;
	localparam int ITEMS_PER_PHASE = 200;
	localparam logic signed [31:0] VMAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] VMIN = 32'sh8000_0000;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	adcu_pkg::in_item_t   in_data;
	logic                 out_valid;
	logic                 out_ready;
	adcu_pkg::out_item_t  out_data;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [3:0]           paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	// shadow of the register contents
	logic [1:0]  mode_cfg;
	logic [31:0] k_cfg;
	logic [15:0] rate_cfg;

	adcu_pkg::out_item_t expected_cells[$];
	int        mismatches;
	bit        calm;      // last part of the run: no idling on either side
	bit        hold_req;  // ask the receiver for a long hold-off

	typedef struct {
		adcu_pkg::in_item_t  nbhd;
		bit                  typed;
		adcu_pkg::out_item_t want;
	} stim_row_t;

	anisotropic_diffusion_cell_update DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Round a signed value to Q.16 fewer bits, half away from zero.
	function automatic longint drop16(longint v);
		longint unsigned m;
		m = (v < 0) ? -v : v;
		m = (m + 64'd32768) >> 16;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	// Predict the smoothed centre from the current register shadow.
	function automatic adcu_pkg::out_item_t smooth_cell(adcu_pkg::in_item_t c);
		longint          nbr [8];
		longint unsigned mag [8];
		bit              neg [8];
		longint unsigned k, s, t, r, g, acc, h, den;
		longint          centre, d, sum, res;
		bit              zero_all;
		adcu_pkg::out_item_t o;
		nbr[0] = longint'($signed(c.north_value));
		nbr[1] = longint'($signed(c.east_value));
		nbr[2] = longint'($signed(c.south_value));
		nbr[3] = longint'($signed(c.west_value));
		nbr[4] = longint'($signed(c.northwest_value));
		nbr[5] = longint'($signed(c.northeast_value));
		nbr[6] = longint'($signed(c.southeast_value));
		nbr[7] = longint'($signed(c.southwest_value));
		centre = longint'($signed(c.centre_value));
		k = (k_cfg == 0) ? 64'd1 : 64'(k_cfg);
		zero_all = (mode_cfg == adcu_pkg::MODE_NONE);
		sum = 0;
		for (int i = 0; i < 8; i++) begin
			d = nbr[i] - centre;
			neg[i] = d < 0;
			mag[i] = neg[i] ? -d : d;
			// diagonals are a factor sqrt 2 further away
			if (i >= 4)
				mag[i] = (mag[i] * 64'(adcu_pkg::SQRT2_Q30) + (64'd1 << 29)) >> 30;
		end
		if (mode_cfg == adcu_pkg::MODE_TUKEY) begin
			s = (k * 64'(adcu_pkg::SQRT2_Q30) + (64'd1 << 29)) >> 30;
			for (int i = 0; i < 8; i++)
				if (mag[i] > s)
					zero_all = 1'b1;
		end
		if (!zero_all) begin
			for (int i = 0; i < 8; i++) begin
				t = (mag[i] << 16) / k;
				if (t > 64'(adcu_pkg::RATIO_CAP))
					t = 64'(adcu_pkg::RATIO_CAP);
				r = (t * t) >> 16;
				case (mode_cfg)
					adcu_pkg::MODE_EXP: begin
						if (r >= (64'd1 << adcu_pkg::EXP_BITS)) begin
							g = 0;
						end else begin
							acc = 64'd1 << 32;
							for (int b = 0; b < adcu_pkg::EXP_BITS; b++)
								if (r[b])
									acc = (acc * 64'(adcu_pkg::EXP_NEG_POW2[b])
										+ (64'd1 << 31)) >> 32;
							g = (acc + 64'd32768) >> 16;
						end
					end
					adcu_pkg::MODE_QUAD: begin
						den = 64'd65536 + r;
						g = ((64'd1 << 32) + (den >> 1)) / den;
					end
					default: begin
						h = ((r >> 1) >= 64'd65536) ? 64'd0 : 64'd65536 - (r >> 1);
						g = (h * h + 64'd65536) >> 17;
					end
				endcase
				if (neg[i])
					sum -= longint'(mag[i] * g);
				else
					sum += longint'(mag[i] * g);
			end
		end
		res = centre + drop16(drop16(sum) * longint'(rate_cfg));
		o.saturated_flag = 1'b0;
		if (res > longint'(VMAX)) begin
			res = VMAX;
			o.saturated_flag = 1'b1;
		end else if (res < longint'(VMIN)) begin
			res = VMIN;
			o.saturated_flag = 1'b1;
		end
		o.smoothed_value = res[31:0];
		return o;
	endfunction

	// APB write: setup cycle, then access cycle; the register takes the value
	// at the edge that ends the access cycle.
	task automatic reg_write(input logic [3:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (addr)
			REG_MODE: mode_cfg = value[1:0];
			REG_K:    k_cfg    = value;
			default:  rate_cfg = value[15:0];
		endcase
	endtask

	// Wait for the pipe to empty, then reprogram all three registers.
	task automatic reconfigure(input logic [1:0] m, input logic [31:0] k,
			input logic [15:0] r);
		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		reg_write(REG_MODE, {30'd0, m});
		reg_write(REG_K, k);
		reg_write(REG_RATE, {16'd0, r});
	endtask

	// Offer one transaction and hold it until taken; record what it should give.
	task automatic offer_cell(input adcu_pkg::in_item_t c, input bit typed,
			input adcu_pkg::out_item_t want);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= c;
		do
			@(posedge clk);
		while (!in_ready);
		expected_cells.push_back(typed ? want : smooth_cell(c));
	endtask

	// Random neighbourhood: the spread decides which part of the conductance
	// curve is hit, so it is drawn over the whole range of scales.
	function automatic adcu_pkg::in_item_t random_cell();
		adcu_pkg::in_item_t c;
		int       shift;
		int       flavour;
		logic signed [31:0] base;
		flavour = $urandom_range(0, 9);
		case (flavour)
			0: base = VMAX - $urandom_range(0, 4000);
			1: base = VMIN + $urandom_range(0, 4000);
			default: base = $urandom;
		endcase
		c.centre_value = base;
		shift = $urandom_range(0, 31);
		if (flavour == 2) begin
			c.north_value     = $urandom;
			c.east_value      = $urandom;
			c.south_value     = $urandom;
			c.west_value      = $urandom;
			c.northwest_value = $urandom;
			c.northeast_value = $urandom;
			c.southeast_value = $urandom;
			c.southwest_value = $urandom;
		end else begin
			c.north_value     = base + ($signed($urandom) >>> shift);
			c.east_value      = base + ($signed($urandom) >>> shift);
			c.south_value     = base + ($signed($urandom) >>> shift);
			c.west_value      = base + ($signed($urandom) >>> shift);
			c.northwest_value = base + ($signed($urandom) >>> shift);
			c.northeast_value = base + ($signed($urandom) >>> shift);
			c.southeast_value = base + ($signed($urandom) >>> shift);
			c.southwest_value = base + ($signed($urandom) >>> shift);
			// near the rails, pull the four axis neighbours to one side to provoke clipping
			if (flavour == 0) begin
				c.north_value = VMAX;
				c.south_value = VMAX;
				c.east_value  = VMAX;
				c.west_value  = VMAX;
			end else if (flavour == 1) begin
				c.north_value = VMIN;
				c.south_value = VMIN;
				c.east_value  = VMIN;
				c.west_value  = VMIN;
			end
		end
		return c;
	endfunction

	function automatic adcu_pkg::in_item_t flat_cell(input logic signed [31:0] centre,
			input logic signed [31:0] around);
		adcu_pkg::in_item_t c;
		c.centre_value    = centre;
		c.north_value     = around;
		c.east_value      = around;
		c.south_value     = around;
		c.west_value      = around;
		c.northwest_value = around;
		c.northeast_value = around;
		c.southeast_value = around;
		c.southwest_value = around;
		return c;
	endfunction

	// Receiver: random stalls, a long hold-off on request, none in the last part.
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// Check every result against the oldest expectation.
	always @(posedge clk) begin
		adcu_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_cells.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", out_data);
			end else begin
				want = expected_cells.pop_front();
				if (out_data.smoothed_value !== want.smoothed_value
						|| out_data.saturated_flag !== want.saturated_flag) begin
					mismatches++;
					if (mismatches <= 10)
						$display("cell mismatch: expected %h/%b got %h/%b",
							want.smoothed_value, want.saturated_flag,
							out_data.smoothed_value, out_data.saturated_flag);
				end
			end
		end
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#3_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		stim_row_t           rows [$];
		stim_row_t           row;
		adcu_pkg::out_item_t none;
		logic [1:0]  modes [8];
		logic [31:0] ks    [8];
		logic [15:0] rates [8];
		mismatches = 0;
		calm       = 1'b0;
		hold_req   = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		mode_cfg   = adcu_pkg::MODE_EXP;
		k_cfg      = 32'd65536;
		rate_cfg   = 16'd16384;
		none       = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: flat neighbourhoods leave the centre untouched, the
		// rest go through the predictor.
		row.typed = 1'b1;
		row.nbhd = flat_cell(0, 0);           row.want = '{0, 1'b0};    rows.push_back(row);
		row.nbhd = flat_cell(VMAX, VMAX);     row.want = '{VMAX, 1'b0}; rows.push_back(row);
		row.nbhd = flat_cell(VMIN, VMIN);     row.want = '{VMIN, 1'b0}; rows.push_back(row);
		row.nbhd = flat_cell(32'sh1234_5678, 32'sh1234_5678);
		row.want = '{32'sh1234_5678, 1'b0};   rows.push_back(row);
		row.typed = 1'b0;
		row.want = none;
		row.nbhd = flat_cell(VMAX, VMIN);     rows.push_back(row);
		row.nbhd = flat_cell(VMIN, VMAX);     rows.push_back(row);
		row.nbhd = flat_cell(0, 32'sh0001_0000);  rows.push_back(row);
		row.nbhd = flat_cell(0, -32'sh0000_8000); rows.push_back(row);
		row.nbhd = flat_cell(VMAX - 10, VMAX);    rows.push_back(row);
		row.nbhd = flat_cell(VMIN + 10, VMIN);    rows.push_back(row);
		row.nbhd = flat_cell(0, 1);               rows.push_back(row);
		row.nbhd = flat_cell(32'sh5555_5555, 32'shAAAA_AAAA); rows.push_back(row);
		row.nbhd = flat_cell(0, 0);
		row.nbhd.west_value = 32'sh0002_0000;     rows.push_back(row);
		row.nbhd = flat_cell(0, 0);
		row.nbhd.southwest_value = 32'sh0000_C000; rows.push_back(row);
		row.nbhd = flat_cell(0, 0);
		row.nbhd.north_value = VMAX;
		row.nbhd.south_value = VMIN;              rows.push_back(row);
		foreach (rows[i])
			offer_cell(rows[i].nbhd, rows[i].typed, rows[i].want);

		// Register settings per phase, the extremes included; the unused mode
		// code and a zero threshold are covered too.
		modes = '{adcu_pkg::MODE_EXP, adcu_pkg::MODE_QUAD, adcu_pkg::MODE_TUKEY,
			adcu_pkg::MODE_EXP, adcu_pkg::MODE_NONE, adcu_pkg::MODE_TUKEY,
			adcu_pkg::MODE_QUAD, adcu_pkg::MODE_EXP};
		ks    = '{32'd65536, 32'hFFFF_FFFF, 32'd262144, 32'd0,
			32'd1, 32'd1, 32'd655360, 32'h8000_0000};
		rates = '{16'd16384, 16'd65535, 16'd65535, 16'd0,
			16'd30000, 16'd65535, 16'd32768, 16'd65535};
		for (int p = 0; p < 8; p++) begin
			if (p != 0)
				reconfigure(modes[p], ks[p], rates[p]);
			if (p == 7)
				calm = 1'b1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// hold the output off once so the pipe fills and backs up
				if (p == 1 && n == 20)
					hold_req = 1'b1;
				offer_cell(random_cell(), 1'b0, none);
			end
			in_valid <= 1'b0;
			@(posedge clk);
		end

		// Drain and settle.
		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/adcu_pkg.sv
hw/rtl/adcu_div.sv
hw/rtl/adcu_lane.sv
hw/rtl/adcu_merge.sv
hw/rtl/anisotropic_diffusion_cell_update.sv
dv/testbench.sv
